// ----- hdl/ptd_pkg.sv -----
// Package: shared types and constants for the periodic task dispatcher.
package ptd_pkg;
  localparam int MaxTasks = 8;
  localparam int IdxW = $clog2(MaxTasks);
  localparam int CntW = $clog2(MaxTasks + 1);

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_RUN = 2'd1,
    CMD_ADD = 2'd2,
    CMD_ENABLE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK = 2'd0,
    KIND_ADD = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_SUMMARY = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [31:0] task_period;
    logic [31:0] first_due;
    logic [2:0] task_index;
    logic enable_on;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] task_id;
    logic accepted;
    logic [31:0] missed_now;
    logic [31:0] overrun_total;
    logic [31:0] run_total;
    logic [3:0] dispatched_count;
    logic last;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load_in;     // capture input item
    logic do_tick;
    logic do_add;
    logic do_enable;
    logic run_start;   // latch now, clear dispatch count, index 0
    logic task_load;   // read task entry at index
    logic div_start;
    logic task_commit; // write back dispatched task
    logic next_task;   // index++
    logic run_end;     // served_mark <= now
    logic [1:0] emit;  // kind of result to build
    logic emit_en;
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] cmd;
    logic pending;     // served_mark < tick_count
    logic idx_done;    // index >= task_count
    logic task_due;    // enabled and due
    logic div_busy;
  } dp_stat_t;
endpackage

// ----- hdl/ptd_divider.sv -----
// Restoring 32-bit divider, one quotient bit per cycle.
module ptd_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic busy,
  output logic [31:0] quotient
);
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [5:0] count;
  logic [32:0] trial;

  assign trial = {rem, quotient[31]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= 6'd32;
      rem <= '0;
      dsr <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (dsr == '0) begin
        quotient <= '0;
        busy <= 1'b0;
      end else begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quotient <= {quotient[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quotient[31]};
          quotient <= {quotient[30:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) busy <= 1'b0;
      end
    end
  end
endmodule

// ----- hdl/ptd_datapath.sv -----
// Datapath: task table, tick counter, pass arithmetic and result building.
module ptd_datapath (
  input  logic clk,
  input  logic rst,
  input  ptd_pkg::in_item_t in_data,
  input  ptd_pkg::dp_cmd_t dcmd,
  output ptd_pkg::dp_stat_t stat,
  output ptd_pkg::out_item_t res
);
  import ptd_pkg::*;

  in_item_t item;
  logic [31:0] tick_count;
  logic [31:0] served_mark;
  logic [CntW-1:0] task_count;
  logic [31:0] period_table [MaxTasks];
  logic [31:0] due_table [MaxTasks];
  logic [31:0] runs_table [MaxTasks];
  logic [31:0] overrun_table [MaxTasks];
  logic [MaxTasks-1:0] enable_bits;

  logic [31:0] now;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] dcount;
  logic [31:0] cur_period, cur_due, cur_runs, cur_ovr;
  logic cur_en;
  logic [31:0] t_now;
  logic div_busy;
  logic [31:0] quotient;
  logic [31:0] step;
  logic add_ok;
  logic [IdxW-1:0] widx;
  logic [IdxW-1:0] eidx;
  out_item_t res_next;

  assign t_now = now - 32'd1;
  assign add_ok = (item.task_period != '0) && (task_count < CntW'(MaxTasks));
  assign widx = idx[IdxW-1:0];
  assign eidx = IdxW'(item.task_index);
  assign step = quotient + 32'd1;

  ptd_divider u_div (
    .clk(clk), .rst(rst), .start(dcmd.div_start),
    .dividend(t_now - cur_due), .divisor(cur_period),
    .busy(div_busy), .quotient(quotient)
  );

  assign stat.cmd = item.cmd;
  assign stat.pending = served_mark < tick_count;
  assign stat.idx_done = idx >= task_count;
  assign stat.task_due = cur_en && (t_now >= cur_due);
  assign stat.div_busy = div_busy;

  always_comb begin
    res_next = '0;
    res_next.kind = dcmd.emit;
    case (dcmd.emit)
      KIND_ACK: res_next.last = 1'b1;
      KIND_ADD: begin
        res_next.last = 1'b1;
        res_next.accepted = add_ok;
        res_next.task_id = add_ok ? 3'(task_count) : 3'd0;
      end
      KIND_DISPATCH: begin
        res_next.task_id = 3'(idx);
        res_next.missed_now = quotient;
        res_next.overrun_total = cur_ovr;
        res_next.run_total = cur_runs;
      end
      default: begin
        res_next.last = 1'b1;
        res_next.dispatched_count = 4'(dcount);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      served_mark <= '0;
      task_count <= '0;
      idx <= '0;
      dcount <= '0;
    end else begin
      if (dcmd.load_in) item <= in_data;
      if (dcmd.do_tick) tick_count <= tick_count + 32'd1;
      if (dcmd.do_add && add_ok) begin
        period_table[task_count[IdxW-1:0]] <= item.task_period;
        due_table[task_count[IdxW-1:0]] <= item.first_due;
        runs_table[task_count[IdxW-1:0]] <= '0;
        overrun_table[task_count[IdxW-1:0]] <= '0;
        enable_bits[task_count[IdxW-1:0]] <= 1'b1;
        task_count <= task_count + CntW'(1);
      end
      if (dcmd.do_enable && (CntW'(item.task_index) < task_count))
        enable_bits[eidx] <= item.enable_on;
      if (dcmd.run_start) begin
        now <= tick_count;
        idx <= '0;
        dcount <= '0;
      end
      if (dcmd.task_load) begin
        cur_period <= period_table[widx];
        cur_due <= due_table[widx];
        cur_runs <= runs_table[widx];
        cur_ovr <= overrun_table[widx];
        cur_en <= enable_bits[widx];
      end
      if (dcmd.task_commit) begin
        cur_ovr <= cur_ovr + quotient;
        cur_runs <= cur_runs + 32'd1;
        overrun_table[widx] <= cur_ovr + quotient;
        runs_table[widx] <= cur_runs + 32'd1;
        due_table[widx] <= cur_due + step * cur_period;
        dcount <= dcount + CntW'(1);
      end
      if (dcmd.next_task) idx <= idx + CntW'(1);
      if (dcmd.run_end) served_mark <= now;
      if (dcmd.emit_en) res <= res_next;
    end
  end
endmodule

// ----- hdl/ptd_control.sv -----
// Controller: sequences commands and the per-task dispatch walk.
module ptd_control (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  ptd_pkg::dp_stat_t stat,
  output ptd_pkg::dp_cmd_t dcmd
);
  import ptd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_LOAD, S_CHECK, S_DIV, S_COMMIT, S_EMIT_D, S_WAIT_D,
    S_SUMMARY, S_WAIT_F
  } state_t;

  state_t state;
  logic [1:0] emit_q;
  logic emit_q_en;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    dcmd = '0;
    dcmd.load_in = in_valid && in_ready;
    dcmd.emit = emit_q;
    dcmd.emit_en = emit_q_en;
    case (state)
      S_DECODE: begin
        dcmd.do_tick = stat.cmd == CMD_TICK;
        dcmd.do_enable = stat.cmd == CMD_ENABLE;
        dcmd.run_start = stat.cmd == CMD_RUN;
      end
      S_LOAD: dcmd.task_load = 1'b1;
      S_CHECK: dcmd.div_start = stat.task_due;
      S_COMMIT: dcmd.task_commit = 1'b1;
      S_WAIT_D: dcmd.next_task = 1'b1;
      S_SUMMARY: dcmd.run_end = stat.pending;
      default: ;
    endcase
    // table write lands on the edge that builds the add outcome
    if (emit_q_en && emit_q == KIND_ADD) dcmd.do_add = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      emit_q <= KIND_ACK;
      emit_q_en <= 1'b0;
    end else begin
      emit_q_en <= (state == S_DECODE && stat.cmd != CMD_RUN) || (state == S_EMIT_D) ||
                   (state == S_SUMMARY);
      if (emit_q_en) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) state <= S_DECODE;
        S_DECODE: begin
          case (stat.cmd)
            CMD_RUN: state <= S_LOAD;
            CMD_ADD: begin
              emit_q <= KIND_ADD; state <= S_WAIT_F;
            end
            default: begin
              emit_q <= KIND_ACK; state <= S_WAIT_F;
            end
          endcase
        end
        S_LOAD: state <= (!stat.pending || stat.idx_done) ? S_SUMMARY : S_CHECK;
        S_CHECK: state <= stat.task_due ? S_DIV : S_WAIT_D;
        S_DIV: if (!stat.div_busy) state <= S_COMMIT;
        S_COMMIT: state <= S_EMIT_D;
        S_EMIT_D: begin
          emit_q <= KIND_DISPATCH; state <= S_WAIT_F;
        end
        S_WAIT_F: begin
          if (!emit_q_en && !out_valid)
            state <= (emit_q == KIND_DISPATCH) ? S_WAIT_D : S_IDLE;
        end
        S_WAIT_D: state <= S_LOAD;
        S_SUMMARY: begin
          emit_q <= KIND_SUMMARY; state <= S_WAIT_F;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/periodic_task_dispatcher.sv -----
// Top level: periodic task dispatcher with up to eight tasks.
// One item at a time. Tick, add and enable each give one result, and the block is
// ready again once that result is taken. A run pass with ticks pending loads and
// checks each task in turn; a due task also goes through the bit-serial 32-bit
// division of lateness by period, a write-back and a dispatch result. Every pass
// ends with a summary result. An output stall holds the block until the result is
// taken. Results leave through a single output register.
module periodic_task_dispatcher (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  ptd_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output ptd_pkg::out_item_t out_data
);
  import ptd_pkg::*;

  dp_cmd_t dcmd;
  dp_stat_t stat;

  ptd_control u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .dcmd(dcmd)
  );

  ptd_datapath u_dp (
    .clk(clk), .rst(rst), .in_data(in_data), .dcmd(dcmd), .stat(stat),
    .res(out_data)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_one_job: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("second item taken");
  a_tick_ack: assert property (@(posedge clk) disable iff (rst)
    dcmd.do_tick |=> ##1 (out_valid && out_data.last))
    else $error("tick without acknowledge");
endmodule
